// ===== rtl/core/fcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types, constants and helpers of the floor and ceiling texel caster.
// ----------------------------------------------------------------------------
package fcc_pkg;

	localparam int ROW_W = 9;
	localparam int COL_W = 10;
	localparam int TEX_W = 6;
	localparam int PIX_W = 19;
	localparam int POS_W = 24;
	localparam int VEC_W = 18;
	localparam int ST_W  = 32;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;

	localparam int SCREEN_WIDTH_DEF  = 1024;
	localparam int SCREEN_HEIGHT_DEF = 512;
	localparam int TEXTURE_SIZE_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF   = 2;

	localparam logic [POS_W-1:0] POS_X_RST   = '0;
	localparam logic [POS_W-1:0] POS_Y_RST   = '0;
	localparam logic [VEC_W-1:0] DIR_X_RST   = 18'd65536;
	localparam logic [VEC_W-1:0] DIR_Y_RST   = '0;
	localparam logic [VEC_W-1:0] PLANE_X_RST = '0;
	localparam logic [VEC_W-1:0] PLANE_Y_RST = 18'd43254;

	// Register index, taken from paddr[4:2].
	typedef enum logic [2:0] {
		REG_POS_X,
		REG_POS_Y,
		REG_DIR_X,
		REG_DIR_Y,
		REG_PLANE_X,
		REG_PLANE_Y
	} reg_idx_t;

	typedef struct packed {
		logic        [POS_W-1:0] pos_x;
		logic        [POS_W-1:0] pos_y;
		logic signed [VEC_W-1:0] dir_x;
		logic signed [VEC_W-1:0] dir_y;
		logic signed [VEC_W-1:0] plane_x;
		logic signed [VEC_W-1:0] plane_y;
	} cfg_t;

	// One classified item waiting for the back end.
	typedef struct packed {
		logic             new_row;
		logic [ROW_W-1:0] row_off;
		logic [PIX_W-1:0] floor_pixel;
		logic [PIX_W-1:0] ceiling_pixel;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_DIV,
		ST_MUL,
		ST_ADJ,
		ST_STEP_DIV,
		ST_EMIT
	} state_t;

	// Which of the four row set-up terms is being formed.
	typedef enum logic [1:0] {
		TERM_STEP_X,
		TERM_STEP_Y,
		TERM_POS_X,
		TERM_POS_Y
	} term_t;

	// Width of the Q16 row distance for a given screen height.
	function automatic int rd_width(input int height);
		return $clog2(height) + 16;
	endfunction

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== rtl/core/fcc_front.sv =====
// ----------------------------------------------------------------------------
// fcc_front
// Accepts pixel requests, drops those off the floor area and works out the
// floor and ceiling pixel indices before queueing the item.
// ----------------------------------------------------------------------------
module fcc_front #(
	parameter int SCREEN_WIDTH  = fcc_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = fcc_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                       push,
	input  logic [fcc_pkg::ROW_W-1:0]  row,
	input  logic [fcc_pkg::COL_W-1:0]  column,
	input  logic                       q_full,
	output logic                       q_push,
	output fcc_pkg::entry_t            q_entry
);

	localparam logic [31:0] HALF_H = 32'(SCREEN_HEIGHT / 2);
	localparam logic [31:0] FULL_H = 32'(SCREEN_HEIGHT);
	localparam logic [31:0] FULL_W = 32'(SCREEN_WIDTH);

	logic [31:0] row_w;
	logic [31:0] col_w;
	logic        on_floor;

	always_comb begin
		row_w    = 32'(row);
		col_w    = 32'(column);
		on_floor = (row_w > HALF_H) && (row_w < FULL_H) && (col_w < FULL_W);

		q_entry.new_row       = (column == '0);
		q_entry.row_off       = fcc_pkg::ROW_W'(row_w - HALF_H);
		q_entry.floor_pixel   = fcc_pkg::PIX_W'(row_w * FULL_W + col_w);
		q_entry.ceiling_pixel = fcc_pkg::PIX_W'((FULL_H - row_w - 32'd1) * FULL_W + col_w);

		// Items that fall outside the floor area are taken and dropped here.
		q_push = push && !q_full && on_floor;
	end

endmodule

// ===== rtl/core/fcc_queue.sv =====
// ----------------------------------------------------------------------------
// fcc_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module fcc_queue #(
	parameter int DEPTH = fcc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_push,
	input  fcc_pkg::entry_t q_din,
	input  logic            q_pop,
	output fcc_pkg::entry_t q_dout,
	output logic            q_full,
	output logic            q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fcc_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign q_full  = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign q_dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (q_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (q_push && !q_pop) begin
				count_q <= count_q + CW'(1);
			end else if (q_pop && !q_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			mem_q[wr_ptr_q] <= q_din;
		end
	end

endmodule

// ===== rtl/core/fcc_div.sv =====
// ----------------------------------------------------------------------------
// fcc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcc_div #(
	parameter int DW = 29,
	parameter int VW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          div_start,
	input  logic [DW-1:0] div_dividend,
	input  logic [VW-1:0] div_divisor,
	output logic          div_busy,
	output logic [DW-1:0] div_quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [VW:0]   shifted;
	logic [VW:0]   trial;

	always_comb begin
		shifted = {rem_q, quo_q[DW-1]};
		trial   = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (div_start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CW'(1));
			cnt_q  <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			quo_q <= div_dividend;
			rem_q <= '0;
			dvs_q <= div_divisor;
		end else if (busy_q) begin
			if (!trial[VW]) begin
				rem_q <= trial[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign div_busy     = busy_q;
	assign div_quotient = quo_q;

endmodule

// ===== rtl/core/fcc_back.sv =====
// ----------------------------------------------------------------------------
// fcc_back
// Sets up the floor walk at the start of each row, then gives one texel
// result per queued item and advances the floor position.
// ----------------------------------------------------------------------------
module fcc_back #(
	parameter int SCREEN_WIDTH  = fcc_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = fcc_pkg::SCREEN_HEIGHT_DEF,
	parameter int TEXTURE_SIZE  = fcc_pkg::TEXTURE_SIZE_DEF,
	parameter int DW            = 29,
	parameter int VW            = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fcc_pkg::cfg_t              cfg,
	input  fcc_pkg::entry_t            q_head,
	input  logic                       q_empty,
	output logic                       q_pop,
	output logic                       div_start,
	output logic [DW-1:0]              div_dividend,
	output logic [VW-1:0]              div_divisor,
	input  logic                       div_busy,
	input  logic [DW-1:0]              div_quotient,
	input  logic                       pop,
	output logic                       empty,
	output logic [fcc_pkg::TEX_W-1:0]  tex_x,
	output logic [fcc_pkg::TEX_W-1:0]  tex_y,
	output logic [fcc_pkg::PIX_W-1:0]  floor_pixel,
	output logic [fcc_pkg::PIX_W-1:0]  ceiling_pixel
);

	localparam int RDW = fcc_pkg::rd_width(SCREEN_HEIGHT);
	localparam int OPW = fcc_pkg::VEC_W + 1;
	localparam int PW  = RDW + 20;
	localparam int TPW = 16 + $clog2(TEXTURE_SIZE + 1);
	localparam int SW  = fcc_pkg::ST_W;
	localparam int RS  = DW + $clog2(SCREEN_WIDTH);
	localparam int RPW = 2 * DW + 1;

	localparam logic [DW-1:0]  RD_NUM   = DW'(SCREEN_HEIGHT) << 15;
	localparam logic [TPW-1:0] TEX_MUL  = TPW'(TEXTURE_SIZE);
	localparam logic [TPW-1:0] TEX_MASK = TPW'(TEXTURE_SIZE - 1);

	// Rounded-up reciprocal of the screen width; with RS = DW + ceil(log2(width))
	// the product shifted down by RS is the exact quotient of any DW-bit value.
	localparam logic [RPW-1:0] RECIP =
		RPW'(((64'd1 << RS) + 64'(SCREEN_WIDTH - 1)) / 64'(SCREEN_WIDTH));

	fcc_pkg::state_t state_q, state_d;
	fcc_pkg::term_t  term_q;
	fcc_pkg::entry_t entry_q;

	logic [RDW-1:0]       rd_q;
	logic signed [PW-1:0] prod_q;
	logic [DW-1:0]        shr_q;
	logic [SW-1:0]        fpx_q, fpy_q, stx_q, sty_q;

	logic                      out_valid_q;
	logic [fcc_pkg::TEX_W-1:0] tex_x_q, tex_y_q;
	logic [fcc_pkg::PIX_W-1:0] fpix_q, cpix_q;

	logic                  out_free;
	logic                  take_row;
	logic                  emit;
	logic                  emit_head;
	logic signed [OPW-1:0] op_sel;
	logic signed [PW-1:0]  mul_a, mul_b;
	logic [PW-1:0]         mag;
	logic [DW-1:0]         shr;
	logic [SW-1:0]         term_abs;
	logic [SW-1:0]         term_val;
	logic [RPW-1:0]        rcp_prod;
	logic [SW-1:0]         quo_abs;
	logic [SW-1:0]         quo_val;
	logic [TPW-1:0]        tpx, tpy;
	fcc_pkg::entry_t       emit_src;

	assign out_free = !out_valid_q || pop;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fcc_pkg::ST_IDLE: begin
				if (!q_empty && q_head.new_row) begin
					state_d = fcc_pkg::ST_RD_DIV;
				end
			end
			fcc_pkg::ST_RD_DIV: begin
				if (!div_busy) begin
					state_d = fcc_pkg::ST_MUL;
				end
			end
			fcc_pkg::ST_MUL: begin
				state_d = fcc_pkg::ST_ADJ;
			end
			fcc_pkg::ST_ADJ: begin
				if (term_q == fcc_pkg::TERM_STEP_X || term_q == fcc_pkg::TERM_STEP_Y) begin
					state_d = fcc_pkg::ST_STEP_DIV;
				end else if (term_q == fcc_pkg::TERM_POS_Y) begin
					state_d = fcc_pkg::ST_EMIT;
				end else begin
					state_d = fcc_pkg::ST_MUL;
				end
			end
			fcc_pkg::ST_STEP_DIV: begin
				state_d = fcc_pkg::ST_MUL;
			end
			fcc_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = fcc_pkg::ST_IDLE;
				end
			end
			default: state_d = fcc_pkg::ST_IDLE;
		endcase
	end

	// Arithmetic shared by the set-up steps.
	always_comb begin
		case (term_q)
			fcc_pkg::TERM_STEP_X: op_sel = {cfg.plane_x, 1'b0};
			fcc_pkg::TERM_STEP_Y: op_sel = {cfg.plane_y, 1'b0};
			fcc_pkg::TERM_POS_X:  op_sel = OPW'(cfg.dir_x) - OPW'(cfg.plane_x);
			fcc_pkg::TERM_POS_Y:  op_sel = OPW'(cfg.dir_y) - OPW'(cfg.plane_y);
			default:              op_sel = '0;
		endcase
		mul_a    = PW'($signed({1'b0, rd_q}));
		mul_b    = PW'(op_sel);
		mag      = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
		shr      = mag[PW-1:16];
		term_abs = SW'(shr);
		term_val = prod_q[PW-1] ? (SW'(0) - term_abs) : term_abs;
		rcp_prod = RPW'(shr_q) * RECIP;
		quo_abs  = SW'(rcp_prod >> RS);
		quo_val  = prod_q[PW-1] ? (SW'(0) - quo_abs) : quo_abs;
		tpx      = TPW'(fpx_q[15:0]) * TEX_MUL;
		tpy      = TPW'(fpy_q[15:0]) * TEX_MUL;
	end

	// Control outputs.
	always_comb begin
		q_pop        = 1'b0;
		take_row     = 1'b0;
		emit         = 1'b0;
		emit_head    = 1'b0;
		div_start    = 1'b0;
		div_dividend = RD_NUM;
		div_divisor  = VW'(q_head.row_off);
		case (state_q)
			fcc_pkg::ST_IDLE: begin
				if (!q_empty) begin
					if (q_head.new_row) begin
						q_pop     = 1'b1;
						take_row  = 1'b1;
						div_start = 1'b1;
					end else if (out_free) begin
						q_pop     = 1'b1;
						emit      = 1'b1;
						emit_head = 1'b1;
					end
				end
			end
			fcc_pkg::ST_EMIT: begin
				emit = out_free;
			end
			default: begin
			end
		endcase
		emit_src = emit_head ? q_head : entry_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fcc_pkg::ST_IDLE;
			term_q      <= fcc_pkg::TERM_STEP_X;
			out_valid_q <= 1'b0;
			fpx_q       <= '0;
			fpy_q       <= '0;
			stx_q       <= '0;
			sty_q       <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == fcc_pkg::ST_RD_DIV && !div_busy) begin
				term_q <= fcc_pkg::TERM_STEP_X;
			end else if (state_q == fcc_pkg::ST_STEP_DIV) begin
				term_q <= fcc_pkg::term_t'(term_q + 2'd1);
				if (term_q == fcc_pkg::TERM_STEP_X) begin
					stx_q <= quo_val;
				end else begin
					sty_q <= quo_val;
				end
			end else if (state_q == fcc_pkg::ST_ADJ && term_q == fcc_pkg::TERM_POS_X) begin
				term_q <= fcc_pkg::TERM_POS_Y;
				fpx_q  <= SW'(cfg.pos_x) + term_val;
			end else if (state_q == fcc_pkg::ST_ADJ && term_q == fcc_pkg::TERM_POS_Y) begin
				fpy_q  <= SW'(cfg.pos_y) + term_val;
			end else if (emit) begin
				fpx_q <= fpx_q + stx_q;
				fpy_q <= fpy_q + sty_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_row) begin
			entry_q <= q_head;
		end
		if (state_q == fcc_pkg::ST_RD_DIV && !div_busy) begin
			rd_q <= div_quotient[RDW-1:0];
		end
		if (state_q == fcc_pkg::ST_MUL) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == fcc_pkg::ST_ADJ) begin
			shr_q <= shr;
		end
		if (emit) begin
			tex_x_q <= fcc_pkg::TEX_W'((tpx >> 16) & TEX_MASK);
			tex_y_q <= fcc_pkg::TEX_W'((tpy >> 16) & TEX_MASK);
			fpix_q  <= emit_src.floor_pixel;
			cpix_q  <= emit_src.ceiling_pixel;
		end
	end

	assign empty         = !out_valid_q;
	assign tex_x         = tex_x_q;
	assign tex_y         = tex_y_q;
	assign floor_pixel   = fpix_q;
	assign ceiling_pixel = cpix_q;

endmodule

// ===== rtl/core/floor_ceiling_texel_caster_core.sv =====
// ----------------------------------------------------------------------------
// floor_ceiling_texel_caster_core
// Floor and ceiling casting for a raycaster: texel coordinates and pixel
// indices for each floor pixel request.
// ----------------------------------------------------------------------------
// A pixel request whose column is not zero is taken from the head of the
// internal queue as soon as the output register is free, and its result is
// registered there, so such pixels stream at one per cycle while results are
// popped. A request with column zero first sets up the row: the row distance
// comes from a one-bit-per-cycle divider, then the two steps and the start
// position are worked out on one shared multiplier, each step being divided
// by the screen width through a reciprocal multiplication; its result then
// waits for the output register to be free. Requests outside the floor area
// are taken and give no result. The queue in front of the back end keeps
// accepting while a result waits to be popped, until it is full. Player
// position, direction and camera plane must only be written while the block
// is idle.
// ----------------------------------------------------------------------------
module floor_ceiling_texel_caster_core #(
	parameter int SCREEN_WIDTH  = fcc_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = fcc_pkg::SCREEN_HEIGHT_DEF,
	parameter int TEXTURE_SIZE  = fcc_pkg::TEXTURE_SIZE_DEF,
	parameter int QUEUE_DEPTH   = fcc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fcc_pkg::ADDR_W-1:0]  paddr,
	input  logic [fcc_pkg::DATA_W-1:0]  pwdata,
	output logic [fcc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic [fcc_pkg::ROW_W-1:0]   row,
	input  logic [fcc_pkg::COL_W-1:0]   column,
	input  logic                        pop,
	output logic                        empty,
	output logic [fcc_pkg::TEX_W-1:0]   tex_x,
	output logic [fcc_pkg::TEX_W-1:0]   tex_y,
	output logic [fcc_pkg::PIX_W-1:0]   floor_pixel,
	output logic [fcc_pkg::PIX_W-1:0]   ceiling_pixel
);

	localparam int RDW = fcc_pkg::rd_width(SCREEN_HEIGHT);
	localparam int DW  = RDW + 4;
	localparam int VW  = fcc_pkg::max_int(fcc_pkg::ROW_W, $clog2(SCREEN_WIDTH + 1));

	fcc_pkg::cfg_t     cfg_q;
	fcc_pkg::reg_idx_t reg_idx;
	logic              cfg_wr;

	fcc_pkg::entry_t q_entry;
	fcc_pkg::entry_t q_head;
	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;

	logic          div_start;
	logic [DW-1:0] div_dividend;
	logic [VW-1:0] div_divisor;
	logic          div_busy;
	logic [DW-1:0] div_quotient;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = fcc_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x   <= fcc_pkg::POS_X_RST;
			cfg_q.pos_y   <= fcc_pkg::POS_Y_RST;
			cfg_q.dir_x   <= fcc_pkg::DIR_X_RST;
			cfg_q.dir_y   <= fcc_pkg::DIR_Y_RST;
			cfg_q.plane_x <= fcc_pkg::PLANE_X_RST;
			cfg_q.plane_y <= fcc_pkg::PLANE_Y_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				fcc_pkg::REG_POS_X:   cfg_q.pos_x   <= pwdata[fcc_pkg::POS_W-1:0];
				fcc_pkg::REG_POS_Y:   cfg_q.pos_y   <= pwdata[fcc_pkg::POS_W-1:0];
				fcc_pkg::REG_DIR_X:   cfg_q.dir_x   <= pwdata[fcc_pkg::VEC_W-1:0];
				fcc_pkg::REG_DIR_Y:   cfg_q.dir_y   <= pwdata[fcc_pkg::VEC_W-1:0];
				fcc_pkg::REG_PLANE_X: cfg_q.plane_x <= pwdata[fcc_pkg::VEC_W-1:0];
				fcc_pkg::REG_PLANE_Y: cfg_q.plane_y <= pwdata[fcc_pkg::VEC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			fcc_pkg::REG_POS_X:   prdata = fcc_pkg::DATA_W'(cfg_q.pos_x);
			fcc_pkg::REG_POS_Y:   prdata = fcc_pkg::DATA_W'(cfg_q.pos_y);
			fcc_pkg::REG_DIR_X:   prdata = fcc_pkg::DATA_W'(cfg_q.dir_x);
			fcc_pkg::REG_DIR_Y:   prdata = fcc_pkg::DATA_W'(cfg_q.dir_y);
			fcc_pkg::REG_PLANE_X: prdata = fcc_pkg::DATA_W'(cfg_q.plane_x);
			fcc_pkg::REG_PLANE_Y: prdata = fcc_pkg::DATA_W'(cfg_q.plane_y);
			default:              prdata = '0;
		endcase
	end

	assign full = q_full;

	fcc_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.push    (push),
		.row     (row),
		.column  (column),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	fcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.q_din   (q_entry),
		.q_pop   (q_pop),
		.q_dout  (q_head),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	fcc_div #(
		.DW (DW),
		.VW (VW)
	) u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_busy     (div_busy),
		.div_quotient (div_quotient)
	);

	fcc_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.TEXTURE_SIZE  (TEXTURE_SIZE),
		.DW            (DW),
		.VW            (VW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_head        (q_head),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.div_start     (div_start),
		.div_dividend  (div_dividend),
		.div_divisor   (div_divisor),
		.div_busy      (div_busy),
		.div_quotient  (div_quotient),
		.pop           (pop),
		.empty         (empty),
		.tex_x         (tex_x),
		.tex_y         (tex_y),
		.floor_pixel   (floor_pixel),
		.ceiling_pixel (ceiling_pixel)
	);

	// The back end only takes an item that is really waiting in the queue.
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	// A division is never restarted while one is still running.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// An item written into the queue is there on the following cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_empty)
		else $error("queued item lost");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the floor and ceiling texel caster. Pixel requests
// are pushed from a queue, each accepted request is run through a local
// fixed-point model of the floor cast, and every popped texel item is
// compared with the oldest prediction. Camera registers are rewritten over
// the APB port between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int     SCREEN_W      = fcc_pkg::SCREEN_WIDTH_DEF;
	localparam int     SCREEN_H      = fcc_pkg::SCREEN_HEIGHT_DEF;
	localparam int     HALF_H        = SCREEN_H / 2;
	localparam int     TEX_SIZE      = fcc_pkg::TEXTURE_SIZE_DEF;
	localparam longint STEP_DIV      = longint'(SCREEN_W) * 65536;
	localparam int     SETTLE_CYCLES = 200;
	localparam int     PHASE_COUNT   = 8;
	localparam int     PHASE_ITEMS   = 250;
	localparam longint TIMEOUT_NS    = 20_000_000;

	typedef struct packed {
		logic [fcc_pkg::ROW_W-1:0] row;
		logic [fcc_pkg::COL_W-1:0] column;
	} pixel_req_t;

	typedef struct packed {
		logic [fcc_pkg::TEX_W-1:0] tex_x;
		logic [fcc_pkg::TEX_W-1:0] tex_y;
		logic [fcc_pkg::PIX_W-1:0] floor_pixel;
		logic [fcc_pkg::PIX_W-1:0] ceiling_pixel;
	} texel_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [fcc_pkg::ADDR_W-1:0] paddr = '0;
	logic [fcc_pkg::DATA_W-1:0] pwdata = '0;
	logic [fcc_pkg::DATA_W-1:0] prdata;
	logic                       pready;
	logic                       push = 1'b0;
	logic                       full;
	logic [fcc_pkg::ROW_W-1:0]  row = '0;
	logic [fcc_pkg::COL_W-1:0]  column = '0;
	logic                       pop = 1'b0;
	logic                       empty;
	logic [fcc_pkg::TEX_W-1:0]  tex_x;
	logic [fcc_pkg::TEX_W-1:0]  tex_y;
	logic [fcc_pkg::PIX_W-1:0]  floor_pixel;
	logic [fcc_pkg::PIX_W-1:0]  ceiling_pixel;

	pixel_req_t  pixel_queue[$];
	texel_t      texel_expect[$];
	int          unsent_items = 0;
	int          mismatch_count = 0;
	int          send_gap = 0;
	int          recv_gap = 0;
	bit          idle_on = 1'b1;

	// Local copy of the camera registers and of the floor walk.
	fcc_pkg::cfg_t view_cfg;
	logic [31:0]   walk_x, walk_y, walk_step_x, walk_step_y;

	floor_ceiling_texel_caster_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.push          (push),
		.full          (full),
		.row           (row),
		.column        (column),
		.pop           (pop),
		.empty         (empty),
		.tex_x         (tex_x),
		.tex_y         (tex_y),
		.floor_pixel   (floor_pixel),
		.ceiling_pixel (ceiling_pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [fcc_pkg::TEX_W-1:0] texel_coord(input logic [31:0] fp);
		longint t;
		t = (longint'(fp[15:0]) * TEX_SIZE) >>> 16;
		return fcc_pkg::TEX_W'(t & (TEX_SIZE - 1));
	endfunction

	// Advances the floor walk by one accepted floor-area request and records its texel.
	function automatic void cast_pixel(input logic [fcc_pkg::ROW_W-1:0] r,
			input logic [fcc_pkg::COL_W-1:0] c);
		longint p, row_dist, dx, dy, px, py;
		texel_t t;
		if (r <= HALF_H || r >= SCREEN_H)
			return;
		if (c >= SCREEN_W)
			return;
		if (c == 0) begin
			p = longint'(r) - HALF_H;
			row_dist = (longint'(SCREEN_H) * 32768) / p;
			dx = longint'($signed(view_cfg.dir_x));
			dy = longint'($signed(view_cfg.dir_y));
			px = longint'($signed(view_cfg.plane_x));
			py = longint'($signed(view_cfg.plane_y));
			walk_step_x = 32'((row_dist * (2 * px)) / STEP_DIV);
			walk_step_y = 32'((row_dist * (2 * py)) / STEP_DIV);
			walk_x = 32'(longint'(view_cfg.pos_x) + (row_dist * (dx - px)) / 65536);
			walk_y = 32'(longint'(view_cfg.pos_y) + (row_dist * (dy - py)) / 65536);
		end
		t.tex_x = texel_coord(walk_x);
		t.tex_y = texel_coord(walk_y);
		t.floor_pixel = fcc_pkg::PIX_W'(longint'(r) * SCREEN_W + longint'(c));
		t.ceiling_pixel = fcc_pkg::PIX_W'((longint'(SCREEN_H) - longint'(r) - 1) * SCREEN_W
			+ longint'(c));
		texel_expect.push_back(t);
		walk_x = walk_x + walk_step_x;
		walk_y = walk_y + walk_step_y;
	endfunction

	function automatic void flag_mismatch(input string field, input longint want, input longint got);
		if (mismatch_count < 10)
			$display("mismatch on %s: expected %0d, got %0d", field, want, got);
		mismatch_count++;
	endfunction

	// Request driver.
	always @(posedge clk) begin
		pixel_req_t nxt;
		if (arst_n) begin
			if (push && !full) begin
				cast_pixel(row, column);
				unsent_items--;
			end
			if (!(push && full)) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (pixel_queue.size() == 0) begin
					push <= 1'b0;
				end else if (idle_on && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(1, 11) - 1;
					push <= 1'b0;
				end else begin
					nxt = pixel_queue.pop_front();
					push <= 1'b1;
					row <= nxt.row;
					column <= nxt.column;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		texel_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (texel_expect.size() == 0) begin
					flag_mismatch("item with nothing expected, floor_pixel", -1, floor_pixel);
				end else begin
					want = texel_expect.pop_front();
					if (tex_x !== want.tex_x)
						flag_mismatch("tex_x", want.tex_x, tex_x);
					if (tex_y !== want.tex_y)
						flag_mismatch("tex_y", want.tex_y, tex_y);
					if (floor_pixel !== want.floor_pixel)
						flag_mismatch("floor_pixel", want.floor_pixel, floor_pixel);
					if (ceiling_pixel !== want.ceiling_pixel)
						flag_mismatch("ceiling_pixel", want.ceiling_pixel, ceiling_pixel);
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(1, 11) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic queue_pixel(input int r, input int c);
		pixel_req_t q;
		q.row = fcc_pkg::ROW_W'(r);
		q.column = fcc_pkg::COL_W'(c);
		pixel_queue.push_back(q);
		unsent_items++;
	endtask

	// A well-formed row: column zero first, then rising columns.
	task automatic queue_row(input int r, input int len, input int base);
		queue_pixel(r, 0);
		for (int j = 1; j < len; j++)
			queue_pixel(r, base + j);
	endtask

	task automatic queue_random(input int n);
		int made, pick, r, len, base;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				r = $urandom_range(HALF_H + 1, SCREEN_H - 1);
				len = $urandom_range(1, 40);
				base = ($urandom_range(0, 7) == 0) ? (SCREEN_W - len) : 0;
				queue_row(r, len, base);
				made += len;
			end else if (pick < 90) begin
				// Row change without a column zero, so the walk carries on.
				r = $urandom_range(HALF_H + 1, SCREEN_H - 1);
				len = $urandom_range(1, 6);
				base = $urandom_range(1, SCREEN_W - len);
				for (int j = 0; j < len; j++)
					queue_pixel(r, base + j);
				made += len;
			end else begin
				r = $urandom_range(0, SCREEN_H - 1);
				queue_pixel(r, $urandom_range(0, SCREEN_W - 1));
				if (r > HALF_H)
					made++;
			end
		end
	endtask

	task automatic drain_pixels();
		while (unsent_items != 0 || texel_expect.size() != 0)
			@(posedge clk);
		// Ignored requests are dropped at the front and never sit in the block.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input fcc_pkg::reg_idx_t idx,
			input logic [fcc_pkg::DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			fcc_pkg::REG_POS_X: view_cfg.pos_x = value[fcc_pkg::POS_W-1:0];
			fcc_pkg::REG_POS_Y: view_cfg.pos_y = value[fcc_pkg::POS_W-1:0];
			fcc_pkg::REG_DIR_X: view_cfg.dir_x = value[fcc_pkg::VEC_W-1:0];
			fcc_pkg::REG_DIR_Y: view_cfg.dir_y = value[fcc_pkg::VEC_W-1:0];
			fcc_pkg::REG_PLANE_X: view_cfg.plane_x = value[fcc_pkg::VEC_W-1:0];
			fcc_pkg::REG_PLANE_Y: view_cfg.plane_y = value[fcc_pkg::VEC_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [fcc_pkg::DATA_W-1:0] vec_word(
			input logic [fcc_pkg::VEC_W-1:0] v);
		return {{(fcc_pkg::DATA_W - fcc_pkg::VEC_W){v[fcc_pkg::VEC_W-1]}}, v};
	endfunction

	task automatic apply_setting(input int s);
		logic [fcc_pkg::POS_W-1:0] px, py;
		logic [fcc_pkg::VEC_W-1:0] dx, dy, lx, ly;
		logic [fcc_pkg::VEC_W-1:0] vmax, vmin;
		vmax = {1'b0, {(fcc_pkg::VEC_W - 1){1'b1}}};
		vmin = {1'b1, {(fcc_pkg::VEC_W - 1){1'b0}}};
		case (s)
			0: begin
				px = '1; py = '1;
				dx = vmax; dy = vmax; lx = vmax; ly = vmax;
			end
			1: begin
				px = '0; py = '0;
				dx = vmin; dy = vmin; lx = vmin; ly = vmin;
			end
			2: begin
				px = '1; py = '0;
				dx = vmin; dy = vmax; lx = vmax; ly = vmin;
			end
			3: begin
				px = '0; py = '1;
				dx = vmax; dy = vmin; lx = vmin; ly = vmax;
			end
			default: begin
				px = fcc_pkg::POS_W'($urandom);
				py = fcc_pkg::POS_W'($urandom);
				dx = fcc_pkg::VEC_W'($urandom);
				dy = fcc_pkg::VEC_W'($urandom);
				lx = fcc_pkg::VEC_W'($urandom);
				ly = fcc_pkg::VEC_W'($urandom);
			end
		endcase
		write_reg(fcc_pkg::REG_POS_X, {{(fcc_pkg::DATA_W - fcc_pkg::POS_W){1'b0}}, px});
		write_reg(fcc_pkg::REG_POS_Y, {{(fcc_pkg::DATA_W - fcc_pkg::POS_W){1'b0}}, py});
		write_reg(fcc_pkg::REG_DIR_X, vec_word(dx));
		write_reg(fcc_pkg::REG_DIR_Y, vec_word(dy));
		write_reg(fcc_pkg::REG_PLANE_X, vec_word(lx));
		write_reg(fcc_pkg::REG_PLANE_Y, vec_word(ly));
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		view_cfg = '{fcc_pkg::POS_X_RST, fcc_pkg::POS_Y_RST, fcc_pkg::DIR_X_RST,
			fcc_pkg::DIR_Y_RST, fcc_pkg::PLANE_X_RST, fcc_pkg::PLANE_Y_RST};
		walk_x = '0;
		walk_y = '0;
		walk_step_x = '0;
		walk_step_y = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests with the camera as it comes out of reset.
		queue_pixel(257, 0);
		queue_pixel(257, 1);
		queue_pixel(257, 2);
		queue_pixel(257, 1023);
		queue_pixel(511, 0);
		queue_pixel(511, 1);
		queue_pixel(511, 1023);
		queue_pixel(256, 0);
		queue_pixel(0, 0);
		queue_pixel(128, 700);
		queue_pixel(384, 9);
		queue_pixel(300, 0);
		queue_pixel(300, 1);
		queue_pixel(300, 2);
		queue_pixel(450, 511);
		queue_pixel(400, 0);
		queue_pixel(400, 1022);
		queue_pixel(400, 1023);
		drain_pixels();

		for (int s = 0; s < PHASE_COUNT; s++) begin
			apply_setting(s);
			if (s == PHASE_COUNT - 1)
				idle_on = 1'b0;
			queue_row(HALF_H + 1, 3, 0);
			queue_row(SCREEN_H - 1, 3, 0);
			queue_random(PHASE_ITEMS);
			drain_pixels();
		end

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
